/* rtl/core/ccfb_pkg.sv */
// ----------------------------------------------------------------------------
// ccfb_pkg
// Types and constants shared by the dashboard CAN frame builder.
// ----------------------------------------------------------------------------
package ccfb_pkg;

	localparam int CCFB_QUEUE_DEPTH = 2;
	localparam int CRC_STAGES       = 7;
	localparam int IN_TDATA_W       = 56;
	localparam int OUT_TDATA_W      = 80;
	localparam int CFG_INDEX_W      = 2;
	localparam int CFG_DATA_W       = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_ROLLING_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLY      = 2'd1;
	localparam logic [7:0]             CRC_POLY_RESET    = 8'h1D;

	typedef enum logic [3:0] {
		CMD_IGNITION   = 4'd0,
		CMD_SPEED      = 4'd1,
		CMD_RPM        = 4'd2,
		CMD_BLINKERS   = 4'd3,
		CMD_BRIGHTNESS = 4'd4,
		CMD_FUEL       = 4'd5,
		CMD_LIGHTS     = 4'd6,
		CMD_PRESS      = 4'd7,
		CMD_RELEASE    = 4'd8,
		CMD_ACC        = 4'd9
	} cmd_t;

	// frame identifiers
	localparam logic [10:0] ID_IGNITION   = 11'h12F;
	localparam logic [10:0] ID_SPEED      = 11'h1A1;
	localparam logic [10:0] ID_RPM        = 11'h0F3;
	localparam logic [10:0] ID_BLINKERS   = 11'h1F6;
	localparam logic [10:0] ID_BRIGHTNESS = 11'h202;
	localparam logic [10:0] ID_FUEL       = 11'h349;
	localparam logic [10:0] ID_LIGHTS     = 11'h21A;
	localparam logic [10:0] ID_BUTTON     = 11'h1EE;
	localparam logic [10:0] ID_ACC        = 11'h33B;

	// CRC final XOR per message
	localparam logic [7:0] XOR_IGNITION = 8'h44;
	localparam logic [7:0] XOR_SPEED    = 8'hA9;
	localparam logic [7:0] XOR_RPM      = 8'h7A;
	localparam logic [7:0] XOR_ACC      = 8'h6B;

	localparam logic [12:0] RPM_FULL = 13'd6900;
	localparam logic [6:0]  PCT_FULL = 7'd100;

	// reciprocal multipliers: x*43/6900 = (x*6691445)>>30,
	// x*253/100 = (x*10611832)>>22, x*19/100 = (x*796936)>>22, x/100 = (x*41)>>12
	localparam logic [22:0] RPM_RECIP    = 23'd6691445;
	localparam int          RPM_SHIFT    = 30;
	localparam logic [23:0] BRIGHT_RECIP = 24'd10611832;
	localparam logic [19:0] FUEL_RECIP   = 20'd796936;
	localparam int          PCT_SHIFT    = 22;
	localparam logic [5:0]  SPEED_RECIP  = 6'd41;
	localparam int          SPEED_SHIFT  = 12;

	typedef struct packed {
		logic [63:0] payload;
		logic [3:0]  data_length;
		logic [10:0] frame_id;
	} frame_t;

	typedef struct packed {
		logic       crc_en;
		logic [7:0] crc_xor;
		frame_t     frame;
	} item_t;

endpackage

/* rtl/core/ccfb_front.sv */
// ----------------------------------------------------------------------------
// ccfb_front
// Decodes a request, scales the readings and lays out the frame bytes.
// ----------------------------------------------------------------------------
module ccfb_front import ccfb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic [3:0]            rolling_count,
	output logic                  push,
	output item_t                 push_item
);

	logic [3:0]  cmd_raw;
	logic [9:0]  road_speed;
	logic [12:0] engine_rpm;
	logic [3:0]  gear_code;
	logic        left_blink, right_blink;
	logic [6:0]  brightness_pct, fuel_pct;
	logic        main_beam, high_beam, rear_fog, front_fog;

	logic [3:0]  acc_counter_q;
	logic [4:0]  acc_sum;

	logic [12:0] rpm_sat;
	logic [35:0] rpm_prod;
	logic [6:0]  bright_sat, fuel_sat;
	logic [30:0] bright_prod;
	logic [26:0] fuel_prod;
	logic [15:0] speed_prod;
	logic [15:0] speed_word;
	logic [7:0]  gear_byte;
	logic        known;
	logic [7:0]  d [8];

	assign cmd_raw        = s_tdata[3:0];
	assign road_speed     = s_tdata[13:4];
	assign engine_rpm     = s_tdata[26:14];
	assign gear_code      = s_tdata[30:27];
	assign left_blink     = s_tdata[31];
	assign right_blink    = s_tdata[32];
	assign brightness_pct = s_tdata[39:33];
	assign fuel_pct       = s_tdata[46:40];
	assign main_beam      = s_tdata[47];
	assign high_beam      = s_tdata[48];
	assign rear_fog       = s_tdata[49];
	assign front_fog      = s_tdata[50];

	assign rpm_sat    = (engine_rpm > RPM_FULL) ? RPM_FULL : engine_rpm;
	assign bright_sat = (brightness_pct > PCT_FULL) ? PCT_FULL : brightness_pct;
	assign fuel_sat   = (fuel_pct > PCT_FULL) ? PCT_FULL : fuel_pct;

	assign rpm_prod    = {23'd0, rpm_sat} * {13'd0, RPM_RECIP};
	assign bright_prod = {24'd0, bright_sat} * {7'd0, BRIGHT_RECIP};
	assign fuel_prod   = {20'd0, fuel_sat} * {7'd0, FUEL_RECIP};
	assign speed_prod  = {6'd0, road_speed} * {10'd0, SPEED_RECIP};
	// speed*64 + speed/100 stays below 2^16
	assign speed_word  = {road_speed, 6'd0} + {12'd0, speed_prod[15:SPEED_SHIFT]};

	always_comb begin
		priority if (gear_code >= 4'd1 && gear_code <= 4'd9) gear_byte = {4'd0, gear_code} + 8'd4;
		else if (gear_code == 4'd11) gear_byte = 8'd2;
		else if (gear_code == 4'd12) gear_byte = 8'd1;
		else gear_byte = 8'd0;
	end

	always_comb begin
		for (int i = 0; i < 8; i++) d[i] = 8'h00;
		known                       = 1'b1;
		push_item.crc_en            = 1'b0;
		push_item.crc_xor           = 8'h00;
		push_item.frame.frame_id    = ID_BUTTON;
		push_item.frame.data_length = 4'd2;
		unique case (cmd_raw)
			CMD_IGNITION: begin
				push_item.frame.frame_id    = ID_IGNITION;
				push_item.frame.data_length = 4'd8;
				push_item.crc_en            = 1'b1;
				push_item.crc_xor           = XOR_IGNITION;
				d[1] = {4'h8, rolling_count};
				d[2] = 8'h8A; d[3] = 8'hDD; d[4] = 8'hF1;
				d[5] = 8'h01; d[6] = 8'h30; d[7] = 8'h06;
			end
			CMD_SPEED: begin
				push_item.frame.frame_id    = ID_SPEED;
				push_item.frame.data_length = 4'd5;
				push_item.crc_en            = 1'b1;
				push_item.crc_xor           = XOR_SPEED;
				d[1] = {4'hC, rolling_count};
				d[2] = speed_word[7:0];
				d[3] = speed_word[15:8];
				d[4] = (road_speed == 10'd0) ? 8'h81 : 8'h91;
			end
			CMD_RPM: begin
				push_item.frame.frame_id    = ID_RPM;
				push_item.frame.data_length = 4'd8;
				push_item.crc_en            = 1'b1;
				push_item.crc_xor           = XOR_RPM;
				d[1] = {4'h6, rolling_count};
				d[2] = {2'd0, rpm_prod[35:RPM_SHIFT]};
				d[3] = 8'hC0; d[4] = 8'hF0; d[5] = gear_byte;
				d[6] = 8'hFF; d[7] = 8'hFF;
			end
			CMD_BLINKERS: begin
				push_item.frame.frame_id = ID_BLINKERS;
				d[0] = (!left_blink && !right_blink) ? 8'h80 :
				       {2'b10, right_blink, left_blink, 4'h1};
				d[1] = 8'hF0;
			end
			CMD_BRIGHTNESS: begin
				push_item.frame.frame_id = ID_BRIGHTNESS;
				d[0] = bright_prod[29:PCT_SHIFT];
				d[1] = 8'hFF;
			end
			CMD_FUEL: begin
				push_item.frame.frame_id    = ID_FUEL;
				push_item.frame.data_length = 4'd5;
				d[3] = 8'd22 - {3'd0, fuel_prod[26:PCT_SHIFT]};
			end
			CMD_LIGHTS: begin
				push_item.frame.frame_id    = ID_LIGHTS;
				push_item.frame.data_length = 4'd3;
				d[0] = {1'b0, rear_fog, front_fog, 2'b00, main_beam, high_beam, 1'b0};
				d[1] = 8'hC0; d[2] = 8'hF7;
			end
			CMD_PRESS: begin
				d[0] = 8'h40; d[1] = 8'hFF;
			end
			CMD_RELEASE: begin
				d[1] = 8'hFF;
			end
			CMD_ACC: begin
				push_item.frame.frame_id    = ID_ACC;
				push_item.frame.data_length = 4'd6;
				push_item.crc_en            = 1'b1;
				push_item.crc_xor           = XOR_ACC;
				d[1] = {4'hF, acc_counter_q};
				d[2] = 8'h5C; d[3] = 8'h70;
			end
			default: known = 1'b0;
		endcase
		for (int i = 0; i < 8; i++) push_item.frame.payload[8*i +: 8] = d[i];
	end

	assign push = accept && known;

	// acc counter steps by 4 modulo 15
	assign acc_sum = {1'b0, acc_counter_q} + 5'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_counter_q <= 4'd0;
		end else if (accept && cmd_raw == CMD_ACC) begin
			acc_counter_q <= (acc_sum >= 5'd15) ? 4'(acc_sum - 5'd15) : acc_sum[3:0];
		end
	end

endmodule

/* rtl/core/ccfb_queue.sv */
// ----------------------------------------------------------------------------
// ccfb_queue
// Small FIFO that decouples request decode from CRC and output.
// ----------------------------------------------------------------------------
module ccfb_queue import ccfb_pkg::*; #(
	parameter int DEPTH = CCFB_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head_item,
	output logic  empty,
	output logic  full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/ccfb_crc_back.sv */
// ----------------------------------------------------------------------------
// ccfb_crc_back
// CRC8 pipeline, one payload byte per stage, and the output register.
// ----------------------------------------------------------------------------
module ccfb_crc_back import ccfb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             crc_poly,
	input  logic                   head_valid,
	input  item_t                  head_item,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
	                                         input logic [7:0] data,
	                                         input logic [7:0] poly);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	logic [CRC_STAGES-1:0] stg_valid_s;
	item_t                 stg_item_s [CRC_STAGES];
	logic [7:0]            stg_crc_s  [CRC_STAGES];
	logic                  advance;
	logic                  out_valid_q;
	frame_t                out_q;

	// whole pipeline moves together unless the output is held
	assign advance = !out_valid_q || m_tready;
	assign pop     = advance && head_valid;

	for (genvar k = 0; k < CRC_STAGES; k++) begin : g_stage
		logic       in_valid;
		item_t      in_item;
		logic [7:0] in_crc;
		logic [7:0] nxt_crc;

		if (k == 0) begin : g_first
			assign in_valid = head_valid;
			assign in_item  = head_item;
			assign in_crc   = 8'hFF;
		end else begin : g_next
			assign in_valid = stg_valid_s[k-1];
			assign in_item  = stg_item_s[k-1];
			assign in_crc   = stg_crc_s[k-1];
		end

		// byte k+1 is covered when it lies inside the frame
		assign nxt_crc = (in_item.frame.data_length > 4'(k + 1)) ?
		                 crc_byte(in_crc, in_item.frame.payload[8*(k+1) +: 8], crc_poly) :
		                 in_crc;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_valid_s[k] <= 1'b0;
			end else if (advance) begin
				stg_valid_s[k] <= in_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				stg_item_s[k] <= in_item;
				stg_crc_s[k]  <= nxt_crc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= stg_valid_s[CRC_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= stg_item_s[CRC_STAGES-1].frame;
			if (stg_item_s[CRC_STAGES-1].crc_en) begin
				out_q.payload[7:0] <= stg_crc_s[CRC_STAGES-1] ^
				                      stg_item_s[CRC_STAGES-1].crc_xor;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.payload, out_q.data_length, out_q.frame_id};

endmodule

/* rtl/core/cluster_can_frame_builder_core.sv */
// ----------------------------------------------------------------------------
// cluster_can_frame_builder_core
// Dashboard CAN frame builder: request in, one CAN frame out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per transfer: a message selector and the current
//   readings. Each request with a known selector yields one frame on m_*:
//   identifier, data length and eight payload bytes. Unknown selectors are
//   taken and dropped. cfg_we/cfg_index/cfg_wdata write the rolling count
//   nibble and the CRC polynomial; write them only while the block is idle.
//   Path: a request enters the queue at its transfer edge, then passes the
//   seven CRC stages and the output register before it shows on m_tvalid.
//   Throughput: one request per cycle while m_tready is high, set by the
//   seven-stage CRC pipeline that handles one payload byte per stage.
//   Stalls: while m_tready is low the CRC pipeline and output register hold;
//   requests keep going into the queue until it is full, then s_tready drops.
//   Reset: queue and pipeline are emptied, the acc counter and rolling count
//   clear and the polynomial returns to 0x1D.
// ----------------------------------------------------------------------------
module cluster_can_frame_builder_core import ccfb_pkg::*; #(
	parameter int QUEUE_DEPTH = CCFB_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// command[3:0], road_speed[13:4], engine_rpm[26:14], gear_code[30:27],
	// left_blink[31], right_blink[32], brightness_pct[39:33], fuel_pct[46:40],
	// main_beam[47], high_beam[48], rear_fog[49], front_fog[50], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// frame_id[10:0], data_length[14:11], payload[78:15], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic [3:0] rolling_count_q;
	logic [7:0] crc_poly_q;
	logic       accept, push, pop, q_empty, q_full;
	item_t      push_item, head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rolling_count_q <= 4'd0;
			crc_poly_q      <= CRC_POLY_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROLLING_COUNT) rolling_count_q <= cfg_wdata[3:0];
			if (cfg_index == CFG_CRC_POLY)      crc_poly_q      <= cfg_wdata[7:0];
		end
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	ccfb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.s_tdata       (s_tdata),
		.rolling_count (rolling_count_q),
		.push          (push),
		.push_item     (push_item)
	);

	ccfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.empty     (q_empty),
		.full      (q_full)
	);

	ccfb_crc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.crc_poly   (crc_poly_q),
		.head_valid (!q_empty),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
